// ===== rtl/core/alm_pkg.sv =====
// Shared types and codes for the array list engine.
// Used by alm_cell and array_list_engine; no dependencies.
package alm_pkg;

    // Operation codes on the mode input
    typedef enum logic [1:0] {
        MODE_GET      = 2'd0,
        MODE_INDEX_OF = 2'd1,
        MODE_INSERT   = 2'd2,
        MODE_ERASE    = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_ROTATE = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_ERASE  = 2'd3
    } t_cell_op;

    // Control broadcast from the sequencer to the cell row
    typedef struct packed {
        t_cell_op   op;
        logic [6:0] pos;
    } t_cell_ctl;

endpackage

// ===== rtl/core/alm_cell.sv =====
// One storage cell of the list: holds one entry and trades it with its neighbors.
// Depends on alm_pkg.
module alm_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_WIDTH  = 7,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  alm_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);
    import alm_pkg::*;

    logic [DATA_WIDTH-1:0] r_entry;
    logic [DATA_WIDTH-1:0] n_entry;
    logic [IDX_WIDTH-1:0]  w_pos;
    logic [IDX_WIDTH-1:0]  w_idx;

    assign w_pos = IDX_WIDTH'(i_ctl.pos);
    assign w_idx = IDX_WIDTH'(IDX);

    // Next entry: hold, rotate toward cell 0, or shift for insert / erase
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_ROTATE: n_entry = i_right;
            CELL_INSERT: begin
                if (w_idx > w_pos) begin
                    n_entry = i_left;
                end else if (w_idx == w_pos) begin
                    n_entry = i_value;
                end
            end
            CELL_ERASE: begin
                if (w_idx >= w_pos) begin
                    n_entry = i_right;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_data = r_entry;

endmodule

// ===== rtl/core/array_list_engine.sv =====
// Ordered list engine: a row of storage cells plus the sequencer that drives it.
// Depends on alm_pkg and alm_cell.
//
// Usage:
//   Command channel: an item (i_mode, i_index, i_value) is taken at a rising
//   edge where start is high and busy is low. busy stays high while the item
//   is worked on.
//   Result channel: o_valid is high for exactly one cycle with o_data,
//   o_position, o_found, o_status and o_count; the receiver cannot stall it.
//   A new item may be issued in the same cycle that a result is shown.
// Sequencing:
//   insert and erase: the sequencer goes from idle to S_EXEC, where all
//   cells shift together and the result is registered.
//   get and index_of: after S_EXEC the sequencer walks in S_WALK; the whole
//   row rotates once past cell 0, which is the only place entries are read.
//   busy stays high until the result shows, so no new item is taken before.
// Reset (synchronous, active low): the list becomes empty and the sequencer
//   idles. Cell contents are not cleared; only entries below the count are
//   ever read.
module array_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_mode,
    input  logic [6:0]          i_index,
    input  logic [31:0]         i_value,
    output logic                o_valid,
    output logic [31:0]         o_data,
    output logic [5:0]          o_position,
    output logic                o_found,
    output alm_pkg::t_status    o_status,
    output logic [6:0]          o_count
);
    import alm_pkg::*;

    localparam int LW  = $clog2(CAPACITY + 1);
    localparam int SW  = $clog2(CAPACITY);
    localparam int CW  = (LW > 7) ? LW : 7;
    localparam int PW  = (SW > 6) ? SW : 6;
    localparam int DXW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

    t_state                r_state;
    t_mode                 r_mode;
    logic [6:0]            r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [LW-1:0]         r_len;
    logic [SW-1:0]         r_step;
    logic                  r_valid;
    logic [31:0]           r_data;
    logic [5:0]            r_where;
    logic                  r_found;
    t_status               r_status;

    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_cell [CAPACITY];
    logic [DXW-1:0]        w_val_ext;
    logic [DXW-1:0]        w_head_ext;
    logic [CW-1:0]         w_pos_ext;
    logic [CW-1:0]         w_len_ext;
    logic [CW-1:0]         w_stp_ext;
    logic [PW-1:0]         w_where_ext;
    logic                  w_pos_lt_len;
    logic                  w_ins_ok_range;
    logic                  w_full;

    // Width adaptation of fields against the parameterized store
    assign w_val_ext      = DXW'(i_value);
    assign w_head_ext     = DXW'(w_cell[0]);
    assign w_pos_ext      = CW'(r_pos);
    assign w_len_ext      = CW'(r_len);
    assign w_stp_ext      = CW'(r_step);
    assign w_where_ext    = PW'(r_step);
    assign w_pos_lt_len   = (w_pos_ext < w_len_ext);
    assign w_ins_ok_range = (w_pos_ext <= w_len_ext);
    assign w_full         = (w_len_ext >= CW'(CAPACITY));

    // Cell row control
    always_comb begin
        w_ctl.op  = CELL_HOLD;
        w_ctl.pos = r_pos;
        if (r_state == S_WALK) begin
            w_ctl.op = CELL_ROTATE;
        end else if (r_state == S_EXEC) begin
            if (r_mode == MODE_INSERT && w_ins_ok_range && !w_full) begin
                w_ctl.op = CELL_INSERT;
            end else if (r_mode == MODE_ERASE && w_pos_lt_len) begin
                w_ctl.op = CELL_ERASE;
            end
        end
    end

    // Row of cells, closed into a ring
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        alm_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_WIDTH  (CW),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (r_val),
            .i_left  (w_cell[(g + CAPACITY - 1) % CAPACITY]),
            .i_right (w_cell[(g + 1) % CAPACITY]),
            .o_data  (w_cell[g])
        );
    end

    // Sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode  <= t_mode'(i_mode);
                        r_pos   <= i_index;
                        r_val   <= w_val_ext[DATA_WIDTH-1:0];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_data   <= '0;
                    r_where  <= '0;
                    r_found  <= 1'b0;
                    r_step   <= '0;
                    r_status <= ST_OK;
                    unique case (r_mode) inside
                        MODE_GET, MODE_INDEX_OF: begin
                            r_state <= S_WALK;
                        end
                        MODE_INSERT: begin
                            if (!w_ins_ok_range) begin
                                r_status <= ST_RANGE;
                            end else if (w_full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_len <= r_len + LW'(1);
                            end
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        MODE_ERASE: begin
                            if (!w_pos_lt_len) begin
                                r_status <= ST_RANGE;
                            end else begin
                                r_len <= r_len - LW'(1);
                            end
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_WALK: begin
                    // cell 0 holds entry r_step in this cycle
                    r_step <= r_step + SW'(1);
                    if (r_mode == MODE_GET && w_stp_ext == w_pos_ext && w_pos_lt_len) begin
                        r_data <= w_head_ext[31:0];
                    end
                    if (r_mode == MODE_INDEX_OF && !r_found && w_stp_ext < w_len_ext
                        && w_cell[0] == r_val) begin
                        r_found <= 1'b1;
                        r_where <= w_where_ext[5:0];
                    end
                    if (r_step == SW'(CAPACITY - 1)) begin
                        if (r_mode == MODE_GET && !w_pos_lt_len) begin
                            r_status <= ST_RANGE;
                        end
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_data     = r_data;
    assign o_position = r_where;
    assign o_found    = r_found;
    assign o_status   = r_status;
    assign o_count    = w_len_ext[6:0];

    // Checks
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !r_valid)
        else $error("result in the cycle right after accepting an item");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_len_ext <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_found) |-> (r_status == ST_OK))
        else $error("search hit reported with an error status");

    a_len_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != $past(r_len)) |-> r_valid)
        else $error("element count changed without a result");

endmodule
